FILE: rtl/core/tx_descriptor_ring_manager_macros.svh
// ----------------------------------------------------------------------------
// tx descriptor ring manager assertion macros
// implication checks used by the ring manager core
// ----------------------------------------------------------------------------
`ifndef TX_DESCRIPTOR_RING_MANAGER_MACROS_SVH
`define TX_DESCRIPTOR_RING_MANAGER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TDRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdrm check failed");
`define TDRM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdrm check failed");
`else
`define TDRM_ASSERT_IMP(label, clk, rst, ante, cons)
`define TDRM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/tdrm_pkg.sv
// ----------------------------------------------------------------------------
// tdrm_pkg
// shared types and constants of the transmit descriptor ring manager
// ----------------------------------------------------------------------------
package tdrm_pkg;

   localparam logic [1:0] KIND_SEND  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_CLEAN = 2'd2;

   localparam int MAX_RESULTS = 64;
   localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

   typedef enum logic [2:0] {
      ST_SENT      = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_BAD_QUEUE = 3'd2,
      ST_RECLAIMED = 3'd3,
      ST_NOTHING   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_BAD_QUEUE,
      OP_DONE,
      OP_CLEAN
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_EXEC,
      B_DIV,
      B_EMIT,
      B_CQ,
      B_CRD,
      B_CCHK,
      B_FLUSH
   } back_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        queue;
      logic [7:0]  packet_id;
      logic [63:0] buffer_addr;
      logic [11:0] buffer_offset;
      logic [13:0] length;
      logic [63:0] launch_time;
      logic [5:0]  done_index;
      logic [31:0] writeback_time;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  desc_index;
      logic [63:0] dma_address;
      logic [24:0] launch_slot;
      logic [5:0]  tail_index;
      logic [7:0]  reclaimed_id;
      logic [31:0] dma_time;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic        queue;
      logic [7:0]  packet_id;
      logic [63:0] dma_address;
      logic [63:0] launch_time;
      logic [5:0]  done_index;
      logic [31:0] writeback_time;
   } cmd_type;

endpackage

FILE: rtl/core/tdrm_front.sv
// ----------------------------------------------------------------------------
// tdrm_front
// accepts request items, classifies them and forms the command
// ----------------------------------------------------------------------------
module tdrm_front #(
   parameter int RING_DEPTH  = 64,
   parameter int QUEUE_COUNT = 2
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  tdrm_pkg::req_type req_data,
   input  logic              fifo_full,
   output logic              fifo_push,
   output tdrm_pkg::cmd_type fifo_cmd
);

   logic keep;
   logic queue_ok;

   always_comb begin
      queue_ok                = 32'(req_data.queue) < QUEUE_COUNT;
      fifo_cmd.op             = tdrm_pkg::OP_CLEAN;
      fifo_cmd.queue          = req_data.queue;
      fifo_cmd.packet_id      = req_data.packet_id;
      fifo_cmd.dma_address    = req_data.buffer_addr + 64'(req_data.buffer_offset);
      fifo_cmd.launch_time    = req_data.launch_time;
      fifo_cmd.done_index     = req_data.done_index;
      fifo_cmd.writeback_time = req_data.writeback_time;
      keep                    = 1'b0;
      case (req_data.kind)
         tdrm_pkg::KIND_SEND: begin
            fifo_cmd.op = queue_ok ? tdrm_pkg::OP_SEND : tdrm_pkg::OP_BAD_QUEUE;
            keep        = 1'b1;
         end
         tdrm_pkg::KIND_DONE: begin
            fifo_cmd.op = tdrm_pkg::OP_DONE;
            keep        = queue_ok && (32'(req_data.done_index) < RING_DEPTH);
         end
         tdrm_pkg::KIND_CLEAN: begin
            fifo_cmd.op = tdrm_pkg::OP_CLEAN;
            keep        = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = fifo_full;
   assign fifo_push = req_valid && !fifo_full && keep;

endmodule

FILE: rtl/core/tdrm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tdrm_cmd_fifo
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module tdrm_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdrm_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tdrm_pkg::cmd_type head
);

   tdrm_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/tdrm_launch_div.sv
// ----------------------------------------------------------------------------
// tdrm_launch_div
// launch slot unit: time mod one second, two bits a cycle, then 32 ns units
// ----------------------------------------------------------------------------
module tdrm_launch_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] launch_time,
   output logic        done,
   output logic [24:0] launch_slot
);

   localparam int STEPS = 32;
   localparam logic [31:0] NS_X2 = 32'd2000000000;
   localparam logic [31:0] NS_X3 = 32'd3000000000;

   logic [29:0] rem_ff, rem_in;
   logic [63:0] t_ff, t_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] v;

   always_comb begin
      v       = {rem_ff, t_ff[63:62]};
      rem_in  = rem_ff;
      t_in    = t_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         t_in    = launch_time;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (v >= NS_X3) begin
            rem_in = 30'(v - NS_X3);
         end else if (v >= NS_X2) begin
            rem_in = 30'(v - NS_X2);
         end else if (v >= tdrm_pkg::NS_PER_SEC) begin
            rem_in = 30'(v - tdrm_pkg::NS_PER_SEC);
         end else begin
            rem_in = 30'(v);
         end
         t_in   = {t_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      t_ff   <= t_in;
      cnt_ff <= cnt_in;
   end

   assign done        = done_ff;
   assign launch_slot = rem_ff[29:5];

endmodule

FILE: rtl/core/tdrm_back.sv
// ----------------------------------------------------------------------------
// tdrm_back
// ring bookkeeping, descriptor memories, clean walk and result register
// ----------------------------------------------------------------------------
`include "tx_descriptor_ring_manager_macros.svh"

module tdrm_back #(
   parameter int RING_DEPTH  = 64,
   parameter int QUEUE_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  tdrm_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              div_start,
   output logic [63:0]       div_time,
   input  logic              div_done,
   input  logic [24:0]       div_slot,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdrm_pkg::rsp_type rsp_data
);

   localparam int LIVE_Q    = (QUEUE_COUNT < 2) ? QUEUE_COUNT : 2;
   localparam int IW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW        = $clog2(RING_DEPTH + 1);
   localparam int MEM_DEPTH = LIVE_Q * RING_DEPTH;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [FW-1:0] RD_F = FW'(RING_DEPTH);

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] x);
      logic [IW:0] s;
      s = {1'b0, x} + (IW+1)'(1);
      if (s >= (IW+1)'(RING_DEPTH)) begin
         return '0;
      end
      return s[IW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic q, input logic [IW-1:0] idx);
      if (q) begin
         return AW'(RING_DEPTH) + AW'(idx);
      end
      return AW'(idx);
   endfunction

   tdrm_pkg::back_state_type state_ff, state_in;
   tdrm_pkg::cmd_type        cmd_ff, cmd_in;
   tdrm_pkg::rsp_type        res_ff, res_in;
   tdrm_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]            produce_ff [2];
   logic [IW-1:0]            produce_in [2];
   logic [IW-1:0]            cleanp_ff [2];
   logic [IW-1:0]            cleanp_in [2];
   logic [FW-1:0]            free_ff [2];
   logic [FW-1:0]            free_in [2];
   logic [1:0]               walk_q_ff, walk_q_in;
   logic [6:0]               n_ff, n_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [7:0]               pend_id_ff, pend_id_in;
   logic [31:0]              pend_time_ff, pend_time_in;

   logic [7:0]               pkt_mem [MEM_DEPTH];
   logic [31:0]              time_mem [MEM_DEPTH];
   logic                     done_mem [MEM_DEPTH];
   logic [7:0]               pkt_rd_ff;
   logic [31:0]              time_rd_ff;
   logic                     done_rd_ff;

   logic                     out_free;
   logic                     sel_q;
   logic [IW-1:0]            ctx_idx, dat_idx, new_prod;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic                     pkt_we, time_we, done_we, done_bit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sel_q    = (state_ff == tdrm_pkg::B_EXEC) ? cmd_ff.queue : walk_q_ff[0];
   assign rd_addr  = slot_addr(walk_q_ff[0], next_idx(cleanp_ff[walk_q_ff[0]]));
   assign div_time = cmd_ff.launch_time;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      produce_in    = produce_ff;
      cleanp_in     = cleanp_ff;
      free_in       = free_ff;
      walk_q_in     = walk_q_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_time_in  = pend_time_ff;
      cmd_pop       = 1'b0;
      div_start     = 1'b0;
      pkt_we        = 1'b0;
      time_we       = 1'b0;
      done_we       = 1'b0;
      done_bit      = 1'b0;
      ctx_idx       = produce_ff[sel_q];
      dat_idx       = next_idx(ctx_idx);
      new_prod      = next_idx(dat_idx);
      wr_addr       = slot_addr(cmd_ff.queue, dat_idx);
      case (state_ff)
         tdrm_pkg::B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               state_in = tdrm_pkg::B_EXEC;
            end
         end
         tdrm_pkg::B_EXEC: begin
            res_in = '0;
            case (cmd_ff.op)
               tdrm_pkg::OP_DONE: begin
                  wr_addr  = slot_addr(cmd_ff.queue, IW'(cmd_ff.done_index));
                  time_we  = 1'b1;
                  done_we  = 1'b1;
                  done_bit = 1'b1;
                  state_in = tdrm_pkg::B_IDLE;
               end
               tdrm_pkg::OP_BAD_QUEUE: begin
                  res_in.status = tdrm_pkg::ST_BAD_QUEUE;
                  state_in      = tdrm_pkg::B_EMIT;
               end
               tdrm_pkg::OP_SEND: begin
                  if (free_ff[sel_q] <= FW'(2)) begin
                     res_in.status = tdrm_pkg::ST_NO_SPACE;
                     state_in      = tdrm_pkg::B_EMIT;
                  end else begin
                     produce_in[sel_q]  = new_prod;
                     free_in[sel_q]     = free_ff[sel_q] - FW'(2);
                     pkt_we             = 1'b1;
                     done_we            = 1'b1;
                     res_in.status      = tdrm_pkg::ST_SENT;
                     res_in.desc_index  = 6'(dat_idx);
                     res_in.dma_address = cmd_ff.dma_address;
                     res_in.tail_index  = 6'(new_prod);
                     div_start          = 1'b1;
                     state_in           = tdrm_pkg::B_DIV;
                  end
               end
               default: begin
                  walk_q_in     = '0;
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = tdrm_pkg::B_CQ;
               end
            endcase
         end
         tdrm_pkg::B_DIV: begin
            if (div_done) begin
               res_in.launch_slot = div_slot;
               state_in           = tdrm_pkg::B_EMIT;
            end
         end
         tdrm_pkg::B_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = res_ff;
               rsp_data_in.last = 1'b1;
               state_in         = tdrm_pkg::B_IDLE;
            end
         end
         tdrm_pkg::B_CQ: begin
            if (walk_q_ff >= 2'(LIVE_Q)) begin
               state_in = tdrm_pkg::B_FLUSH;
            end else if (free_ff[sel_q] >= RD_F) begin
               walk_q_in = walk_q_ff + 2'd1;
            end else begin
               state_in = tdrm_pkg::B_CRD;
            end
         end
         tdrm_pkg::B_CRD: begin
            state_in = tdrm_pkg::B_CCHK;
         end
         tdrm_pkg::B_CCHK: begin
            if (free_ff[sel_q] < RD_F && n_ff < 7'(tdrm_pkg::MAX_RESULTS) && done_rd_ff) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in              = '0;
                     rsp_data_in.status       = tdrm_pkg::ST_RECLAIMED;
                     rsp_data_in.reclaimed_id = pend_id_ff;
                     rsp_data_in.dma_time     = pend_time_ff;
                  end
                  pend_valid_in    = 1'b1;
                  pend_id_in       = pkt_rd_ff;
                  pend_time_in     = time_rd_ff;
                  n_in             = n_ff + 7'd1;
                  cleanp_in[sel_q] = next_idx(next_idx(cleanp_ff[sel_q]));
                  free_in[sel_q]   = free_ff[sel_q] + FW'(2);
                  state_in         = tdrm_pkg::B_CRD;
               end
            end else begin
               walk_q_in = walk_q_ff + 2'd1;
               state_in  = tdrm_pkg::B_CQ;
            end
         end
         tdrm_pkg::B_FLUSH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = '0;
               rsp_data_in.last = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in.status       = tdrm_pkg::ST_RECLAIMED;
                  rsp_data_in.reclaimed_id = pend_id_ff;
                  rsp_data_in.dma_time     = pend_time_ff;
               end else begin
                  rsp_data_in.status = tdrm_pkg::ST_NOTHING;
               end
               pend_valid_in = 1'b0;
               state_in      = tdrm_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = tdrm_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdrm_pkg::B_IDLE;
         rsp_valid_ff  <= 1'b0;
         produce_ff    <= '{default: '0};
         cleanp_ff     <= '{default: '0};
         free_ff       <= '{default: RD_F};
         walk_q_ff     <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         produce_ff    <= produce_in;
         cleanp_ff     <= cleanp_in;
         free_ff       <= free_in;
         walk_q_ff     <= walk_q_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      pend_id_ff   <= pend_id_in;
      pend_time_ff <= pend_time_in;
   end

   always_ff @(posedge clock) begin
      if (pkt_we) begin
         pkt_mem[wr_addr] <= cmd_ff.packet_id;
      end
      pkt_rd_ff <= pkt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[wr_addr] <= cmd_ff.writeback_time;
      end
      time_rd_ff <= time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (done_we) begin
         done_mem[wr_addr] <= done_bit;
      end
      done_rd_ff <= done_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TDRM_ASSERT_IMP(a_free_bound, clock, reset, 1'b1, free_ff[0] <= RD_F && free_ff[1] <= RD_F)
   `TDRM_ASSERT_IMP(a_pend_in_clean, clock, reset, pend_valid_ff, state_ff == tdrm_pkg::B_CQ || state_ff == tdrm_pkg::B_CRD || state_ff == tdrm_pkg::B_CCHK || state_ff == tdrm_pkg::B_FLUSH)
   `TDRM_ASSERT_NXT(a_div_to_emit, clock, reset, state_ff == tdrm_pkg::B_DIV && div_done, state_ff == tdrm_pkg::B_EMIT)
   `TDRM_ASSERT_IMP(a_result_cap, clock, reset, 1'b1, n_ff <= 7'(tdrm_pkg::MAX_RESULTS))

endmodule

FILE: rtl/core/tx_descriptor_ring_manager.sv
// ----------------------------------------------------------------------------
// tx_descriptor_ring_manager
// transmit descriptor ring bookkeeping for up to two queues
// ----------------------------------------------------------------------------
// Items pass through a two-entry command queue into a back end that handles
// one item at a time. A send item waits for the launch slot unit, which
// reduces the 64-bit launch time modulo one second two bits per cycle. A
// clean item walks each queue, with one read of the descriptor memory per
// reclaimed packet. Descriptor state needs no clearing pass after reset;
// the block takes items at once.
module tx_descriptor_ring_manager #(
   parameter int RING_DEPTH  = 64,
   parameter int QUEUE_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tdrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdrm_pkg::rsp_type rsp_data
);

   tdrm_pkg::cmd_type push_cmd, head_cmd;
   logic              fifo_full, fifo_empty, fifo_push, fifo_pop;
   logic              div_start, div_done;
   logic [63:0]       div_time;
   logic [24:0]       div_slot;

   tdrm_front #(
      .RING_DEPTH (RING_DEPTH),
      .QUEUE_COUNT(QUEUE_COUNT)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .fifo_full(fifo_full),
      .fifo_push(fifo_push),
      .fifo_cmd (push_cmd)
   );

   tdrm_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .push_cmd(push_cmd),
      .full    (fifo_full),
      .pop     (fifo_pop),
      .empty   (fifo_empty),
      .head    (head_cmd)
   );

   tdrm_launch_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .launch_time(div_time),
      .done       (div_done),
      .launch_slot(div_slot)
   );

   tdrm_back #(
      .RING_DEPTH (RING_DEPTH),
      .QUEUE_COUNT(QUEUE_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(fifo_empty),
      .cmd_head (head_cmd),
      .cmd_pop  (fifo_pop),
      .div_start(div_start),
      .div_time (div_time),
      .div_done (div_done),
      .div_slot (div_slot),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

FILE: dv/tx_descriptor_ring_manager_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_descriptor_ring_manager_checker
// watches the request and response channels, predicts every response from
// its own copy of the ring bookkeeping and compares them field by field
// ----------------------------------------------------------------------------
module tx_descriptor_ring_manager_checker
   import tdrm_pkg::*;
#(
   parameter int RING_DEPTH  = 64,
   parameter int QUEUE_COUNT = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   localparam int SLOTS = QUEUE_COUNT * RING_DEPTH;
   localparam logic [6:0] EOP_NONE = 7'h7f;

   logic [6:0]  prod_ptr [QUEUE_COUNT];
   logic [6:0]  reap_ptr [QUEUE_COUNT];
   int          free_desc [QUEUE_COUNT];
   logic        desc_valid [SLOTS];
   logic [7:0]  desc_packet [SLOTS];
   logic [6:0]  desc_eop [SLOTS];
   logic        desc_done [SLOTS];
   logic [31:0] desc_time [SLOTS];

   rsp_type expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic logic [6:0] ring_next(logic [6:0] i);
      return (int'(i) + 1 >= RING_DEPTH) ? 7'd0 : i + 7'd1;
   endfunction

   function automatic rsp_type blank_rsp(status_type st);
      rsp_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   task automatic clear_desc(int s);
      desc_valid[s]  = 1'b0;
      desc_packet[s] = '0;
      desc_eop[s]    = EOP_NONE;
      desc_done[s]   = 1'b0;
      desc_time[s]   = '0;
   endtask

   task automatic predict_send(req_type rq);
      rsp_type r;
      int q, base;
      logic [6:0] ctx, dat;
      q = rq.queue;
      if (q >= QUEUE_COUNT) begin
         r = blank_rsp(ST_BAD_QUEUE);
      end else if (free_desc[q] <= 2) begin
         r = blank_rsp(ST_NO_SPACE);
      end else begin
         base = q * RING_DEPTH;
         ctx = prod_ptr[q];
         dat = ring_next(ctx);
         prod_ptr[q] = ring_next(dat);
         free_desc[q] -= 2;
         clear_desc(base + ctx);
         desc_eop[base + ctx] = dat;
         clear_desc(base + dat);
         desc_valid[base + dat] = 1'b1;
         desc_packet[base + dat] = rq.packet_id;
         r = blank_rsp(ST_SENT);
         r.desc_index  = dat[5:0];
         r.dma_address = rq.buffer_addr + {52'd0, rq.buffer_offset};
         r.launch_slot = 25'((rq.launch_time % 64'd1000000000) / 64'd32);
         r.tail_index  = prod_ptr[q][5:0];
      end
      r.last = 1'b1;
      expected_rsps.push_back(r);
   endtask

   task automatic predict_clean();
      int n, base, visits, s;
      logic [6:0] first, eop, stop;
      rsp_type r;
      n = 0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         base = q * RING_DEPTH;
         visits = 0;
         if (free_desc[q] >= RING_DEPTH) continue;
         first = reap_ptr[q];
         eop = desc_eop[base + first];
         while (eop < RING_DEPTH && desc_done[base + eop] && visits < RING_DEPTH
                && n < MAX_RESULTS) begin
            stop = ring_next(eop);
            do begin
               s = base + first;
               if (desc_valid[s]) begin
                  r = blank_rsp(ST_RECLAIMED);
                  r.reclaimed_id = desc_packet[s];
                  r.dma_time = desc_time[s];
                  expected_rsps.push_back(r);
                  n++;
               end
               clear_desc(s);
               if (free_desc[q] < RING_DEPTH) free_desc[q]++;
               first = ring_next(first);
               visits++;
            end while (first != stop && visits < RING_DEPTH);
            eop = desc_eop[base + first];
         end
         reap_ptr[q] = first;
      end
      if (n == 0) expected_rsps.push_back(blank_rsp(ST_NOTHING));
      r = expected_rsps.pop_back();
      r.last = 1'b1;
      expected_rsps.push_back(r);
   endtask

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         fail_count = 0;
         expected_rsps.delete();
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            prod_ptr[q] = '0;
            reap_ptr[q] = '0;
            free_desc[q] = RING_DEPTH;
         end
         for (int s = 0; s < SLOTS; s++) clear_desc(s);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response status %0d", rsp_data.status);
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               compare_field("status", e.status, rsp_data.status);
               compare_field("desc_index", e.desc_index, rsp_data.desc_index);
               compare_field("dma_address", e.dma_address, rsp_data.dma_address);
               compare_field("launch_slot", e.launch_slot, rsp_data.launch_slot);
               compare_field("tail_index", e.tail_index, rsp_data.tail_index);
               compare_field("reclaimed_id", e.reclaimed_id, rsp_data.reclaimed_id);
               compare_field("dma_time", e.dma_time, rsp_data.dma_time);
               compare_field("last", e.last, rsp_data.last);
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.kind)
               KIND_SEND: begin
                  predict_send(req_data);
               end
               KIND_DONE: begin
                  if (req_data.queue < QUEUE_COUNT && req_data.done_index < RING_DEPTH) begin
                     desc_done[req_data.queue * RING_DEPTH + req_data.done_index] = 1'b1;
                     desc_time[req_data.queue * RING_DEPTH + req_data.done_index] =
                        req_data.writeback_time;
                  end
               end
               KIND_CLEAN: begin
                  predict_clean();
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: dv/tb_tx_descriptor_ring_manager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tx_descriptor_ring_manager
// drives send, done and clean items with random gaps and response stalls;
// a checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module tb_tx_descriptor_ring_manager;
   import tdrm_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      idle_cycles = 0;
   logic    stim_done = 1'b0;

   // done index feed: descriptors sent but not yet reported done, per queue
   int      open_desc [2][$];

   always #1 clock = ~clock;

   tx_descriptor_ring_manager #(.RING_DEPTH(RING_DEPTH), .QUEUE_COUNT(2)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   tx_descriptor_ring_manager_checker #(.RING_DEPTH(RING_DEPTH), .QUEUE_COUNT(2)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin
      if (reset || stim_done && pending_count == 0) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ~rsp_stall;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_tx_descriptor_ring_manager failed");
            $finish;
         end
      end
   end

   task automatic send_item(req_type rq);
      int g;
      g = gap_length();
      repeat (g) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic req_type make_send(logic q);
      req_type rq;
      rq = '0;
      rq.kind = KIND_SEND;
      rq.queue = q;
      rq.packet_id = $urandom();
      rq.buffer_addr = rand64();
      rq.buffer_offset = $urandom();
      rq.length = $urandom();
      rq.launch_time = ($urandom_range(0, 1)) ? rand64() : 64'($urandom());
      rq.done_index = $urandom();
      rq.writeback_time = $urandom();
      return rq;
   endfunction

   function automatic req_type make_done(logic q, int idx);
      req_type rq;
      rq = make_send(q);
      rq.kind = KIND_DONE;
      rq.done_index = idx;
      return rq;
   endfunction

   function automatic req_type make_clean();
      req_type rq;
      rq = make_send($urandom_range(0, 1));
      rq.kind = KIND_CLEAN;
      return rq;
   endfunction

   // data descriptor index of a send, tracked so done items hit real packets
   int prod_model [2];
   int free_model [2];

   task automatic do_send(req_type rq);
      int q;
      q = rq.queue;
      if (free_model[q] > 2) begin
         prod_model[q] = (prod_model[q] + 1) % RING_DEPTH;
         open_desc[q].push_back(prod_model[q]);
         prod_model[q] = (prod_model[q] + 1) % RING_DEPTH;
         free_model[q] -= 2;
      end
      send_item(rq);
   endtask

   task automatic do_done_oldest(logic q);
      int idx;
      if (open_desc[q].size() == 0) return;
      idx = open_desc[q].pop_front();
      send_item(make_done(q, idx));
   endtask

   task automatic do_clean();
      // clean frees done packets; the random loop resyncs the free count to a lower bound
      send_item(make_clean());
   endtask

   initial begin
      req_type rq;
      int p, q;
      prod_model = '{0, 0};
      free_model = '{RING_DEPTH, RING_DEPTH};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty clean, field extremes, unknown kind, done on an unsent slot
      do_clean();
      rq = make_send(1'b0);
      rq.packet_id = 8'hff; rq.buffer_addr = '1; rq.buffer_offset = 12'hfff;
      rq.length = 14'h3fff; rq.launch_time = '1;
      do_send(rq);
      rq = make_send(1'b1);
      rq.packet_id = '0; rq.buffer_addr = '0; rq.buffer_offset = '0;
      rq.length = '0; rq.launch_time = 64'd999999999;
      do_send(rq);
      rq = make_send(1'b0);
      rq.launch_time = 64'd1000000000;
      do_send(rq);
      rq = make_clean();
      rq.kind = 2'd3;
      send_item(rq);
      do_clean();
      do_done_oldest(1'b0);
      rq = make_done(1'b1, 63);
      rq.writeback_time = '1;
      send_item(rq);
      do_done_oldest(1'b1);
      do_clean();
      do_done_oldest(1'b0);
      do_clean();
      do_clean();
      // fill queue 1 until refused, then drain it completely
      for (int i = 0; i < 33; i++) do_send(make_send(1'b1));
      while (open_desc[1].size() > 0) do_done_oldest(1'b1);
      do_clean();
      free_model[1] = RING_DEPTH;
      free_model[0] = RING_DEPTH;
      // queue 0 after clean is empty too since its packets were all done

      for (int i = 0; i < 450; i++) begin
         p = $urandom_range(0, 99);
         q = $urandom_range(0, 1);
         if (p < 45) begin
            do_send(make_send(q));
         end else if (p < 80) begin
            do_done_oldest(q);
         end else if (p < 86) begin
            rq = make_done(q, $urandom_range(0, 63));
            send_item(rq);
         end else if (p < 97) begin
            do_clean();
            // after a clean, the model's free count is a lower bound only
            for (int k = 0; k < 2; k++)
               free_model[k] = RING_DEPTH - 2 * open_desc[k].size() - 2;
         end else begin
            rq = make_clean();
            rq.kind = 2'd3;
            send_item(rq);
         end
      end
      do_clean();
      stim_done <= 1'b1;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_tx_descriptor_ring_manager passed");
      end else begin
         $display("tb_tx_descriptor_ring_manager failed");
      end
      $finish;
   end

endmodule
